// File: src/rrtd_pkg.sv
// Package for the round-robin tick-delay scheduler: task counts, field widths
// and the derived index widths. It has no dependencies.

package rrtd_pkg;

	// Task 0 is the idle task and the rest are user tasks.
	localparam int NUM_TASKS = 5;
	localparam int NUM_USER  = NUM_TASKS - 1;

	// Width of an internal task index.
	localparam int TASK_W = $clog2(NUM_TASKS);

	// Widths of the payload fields.
	localparam int CMD_W  = 1;
	localparam int TICK_W = 32;
	localparam int RUN_W  = 3;
	localparam int MASK_W = 4;

	// Event codes.
	localparam logic [CMD_W-1:0] CMD_TICK  = 1'b0;
	localparam logic [CMD_W-1:0] CMD_DELAY = 1'b1;

endpackage

// File: src/rrtd_in_if.sv
// Event channel of the scheduler: valid/ready handshake with command and delay payload.
// Depends on rrtd_pkg.

interface rrtd_in_if import rrtd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [TICK_W-1:0] delay_ticks;

	modport source (output valid, output cmd, output delay_ticks, input ready);
	modport sink   (input valid, input cmd, input delay_ticks, output ready);
endinterface

// File: src/rrtd_out_if.sv
// Result channel of the scheduler: valid/ready handshake with task, tick and mask payload.
// Depends on rrtd_pkg.

interface rrtd_out_if import rrtd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [RUN_W-1:0]  running_task;
	logic [TICK_W-1:0] tick_now;
	logic [MASK_W-1:0] ready_mask;

	modport source (output valid, output running_task, output tick_now, output ready_mask,
		input ready);
	modport sink   (input valid, input running_task, input tick_now, input ready_mask,
		output ready);
endinterface

// File: src/rrtd_ctrl.sv
// Controller of the scheduler: tracks whether the result register is full and
// decides when an event is committed. Depends on rrtd_pkg.

module rrtd_ctrl import rrtd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output logic commit
);

	localparam logic ST_EMPTY = 1'b0;
	localparam logic ST_FULL  = 1'b1;

	logic state_q;
	logic state_d;

	// A new event is taken whenever the result register is empty or being drained.
	assign in_ready  = (state_q == ST_EMPTY) || out_ready;
	assign commit    = in_valid && in_ready;
	assign out_valid = (state_q == ST_FULL);

	// Next state of the result register.
	always_comb begin
		case (state_q)
			ST_EMPTY: state_d = commit ? ST_FULL : ST_EMPTY;
			ST_FULL:  state_d = (commit || !out_ready) ? ST_FULL : ST_EMPTY;
			default:  state_d = ST_EMPTY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EMPTY;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: src/rrtd_dp.sv
// Datapath of the scheduler: tick counter, wake times, blocked flags, the
// round-robin choice and the result register. Depends on rrtd_pkg.

module rrtd_dp import rrtd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              commit,
	input  logic [CMD_W-1:0]  cmd,
	input  logic [TICK_W-1:0] delay_ticks,
	output logic [RUN_W-1:0]  running_task,
	output logic [TICK_W-1:0] tick_now,
	output logic [MASK_W-1:0] ready_mask
);

	logic [TASK_W-1:0]     cur_q;
	logic [TICK_W-1:0]     tick_q;
	logic [TICK_W-1:0]     wake_q [NUM_USER];
	logic [NUM_USER-1:0]   blocked_q;

	logic [TASK_W-1:0]     cur_d;
	logic [TICK_W-1:0]     tick_d;
	logic [NUM_USER-1:0]   blocked_d;
	logic [NUM_USER-1:0]   wake_we;
	logic [TICK_W-1:0]     wake_sum;
	logic                  resched;
	logic [NUM_TASKS-1:0]  task_rdy;
	logic [TASK_W:0]       cand_sum;
	logic [TASK_W-1:0]     cand;
	logic                  found;
	logic [TASK_W+RUN_W-1:0]    run_pad;
	logic [NUM_USER+MASK_W-1:0] mask_pad;

	assign wake_sum = tick_q + delay_ticks;

	// Event handling: a tick wakes matching blocked tasks, a delay blocks the running task.
	always_comb begin
		tick_d    = tick_q;
		blocked_d = blocked_q;
		wake_we   = '0;
		resched   = 1'b0;
		if (cmd == CMD_TICK) begin
			tick_d  = tick_q + TICK_W'(1);
			resched = 1'b1;
			for (int k = 0; k < NUM_USER; k++) begin
				if (blocked_q[k] && (wake_q[k] == tick_d)) begin
					blocked_d[k] = 1'b0;
				end
			end
		end else if (cur_q != '0) begin
			resched = 1'b1;
			for (int k = 0; k < NUM_USER; k++) begin
				if (cur_q == TASK_W'(k + 1)) begin
					blocked_d[k] = 1'b1;
					wake_we[k]   = 1'b1;
				end
			end
		end
	end

	// Round-robin choice: first ready user task after the current one, else idle.
	assign task_rdy = {~blocked_d, 1'b0};

	always_comb begin
		cur_d    = resched ? '0 : cur_q;
		found    = !resched;
		cand_sum = '0;
		cand     = '0;
		for (int n = 1; n <= NUM_TASKS; n++) begin
			cand_sum = {1'b0, cur_q} + (TASK_W + 1)'(n);
			if (cand_sum >= (TASK_W + 1)'(NUM_TASKS)) begin
				cand_sum = cand_sum - (TASK_W + 1)'(NUM_TASKS);
			end
			cand = cand_sum[TASK_W-1:0];
			if (!found && task_rdy[cand]) begin
				cur_d = cand;
				found = 1'b1;
			end
		end
	end

	// Scheduler state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q     <= TASK_W'(1);
			tick_q    <= '0;
			blocked_q <= '0;
		end else if (commit) begin
			cur_q     <= cur_d;
			tick_q    <= tick_d;
			blocked_q <= blocked_d;
		end
	end

	// Wake times are only compared while a task is blocked, so they need no reset.
	always_ff @(posedge clk) begin
		for (int k = 0; k < NUM_USER; k++) begin
			if (commit && wake_we[k]) begin
				wake_q[k] <= wake_sum;
			end
		end
	end

	// Result register, sized to the output fields.
	assign run_pad  = {{RUN_W{1'b0}}, cur_d};
	assign mask_pad = {{MASK_W{1'b0}}, ~blocked_d};

	always_ff @(posedge clk) begin
		if (commit) begin
			running_task <= run_pad[RUN_W-1:0];
			tick_now     <= tick_d;
			ready_mask   <= mask_pad[MASK_W-1:0];
		end
	end

endmodule

// File: src/round_robin_tick_delay_scheduler_top.sv
// Top level of the round-robin tick-delay scheduler: joins the controller and the datapath.
// Depends on rrtd_pkg, rrtd_in_if, rrtd_out_if, rrtd_ctrl and rrtd_dp.
//
//   Port  Direction  Transfer carries
//   evt   in         cmd (tick or delay request), delay_ticks
//   res   out        running_task, tick_now, ready_mask
//
// Each event is handled directly: the wake compares and the round-robin
// choice are combinational between the state registers and the result register.
// The result appears in the cycle after the event transfer and a new event is taken
// in every cycle that the result register is empty or being drained.
// Reset puts task 1 in the running slot, the tick count at zero and all tasks ready.
// A stall on res holds the result and stops evt only while the register is full.

module round_robin_tick_delay_scheduler_top import rrtd_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	rrtd_in_if.sink   evt,
	rrtd_out_if.source res
);

	logic commit;

	rrtd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (evt.valid),
		.in_ready  (evt.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.commit    (commit)
	);

	rrtd_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.commit       (commit),
		.cmd          (evt.cmd),
		.delay_ticks  (evt.delay_ticks),
		.running_task (res.running_task),
		.tick_now     (res.tick_now),
		.ready_mask   (res.ready_mask)
	);

endmodule
